[sv/prq_pkg.sv]
// Package for the priority ready queue: sizes, operation and status codes,
// request and response structs, cell control and link types. No dependencies.
package prq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int PRIO_WIDTH  = 8;
	localparam int ID_W        = 4;
	localparam int PRIO_IN_W   = 8;
	localparam int OCC_W       = 5;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		FN_INSERT = 2'd0,
		FN_PEEK   = 2'd1,
		FN_POP    = 2'd2,
		FN_REMOVE = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		func_t                 func;
		logic [ID_W-1:0]       proc_id;
		logic [PRIO_IN_W-1:0]  prio_in;
	} req_t;

	typedef struct packed {
		status_t               status;
		logic [ID_W-1:0]       out_id;
		logic [PRIO_IN_W-1:0]  out_prio;
		logic                  is_empty;
		logic [OCC_W-1:0]      occupancy;
	} rsp_t;

	// One stored entry of the queue.
	typedef struct packed {
		logic [ID_W-1:0]       id;
		logic [PRIO_WIDTH-1:0] prio;
	} entry_t;

	// Broadcast from the top level to every cell.
	typedef struct packed {
		logic                  exec;
		func_t                 func;
		logic [ID_W-1:0]       pid;
		logic [PRIO_WIDTH-1:0] prio;
	} ctrl_t;

	// Flags handed from a cell to the next one toward the tail.
	typedef struct packed {
		logic ins;   // insert point is at or before this cell
		logic seen;  // id match at or before this cell
	} link_t;

endpackage

[sv/priority_ready_queue_unit.sv]
// Priority ready queue top level: request/response handshakes, entry count
// and a chain of prq_cell slots. Depends on prq_pkg and prq_cell.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------
//   req     | in        | req_valid/req_stall | func, proc_id, prio_in
//   rsp     | out       | rsp_valid/rsp_stall | status, out_id, out_prio,
//           |           |                    | is_empty, occupancy
//
// A request is registered on acceptance; then the whole chain of cells
// updates together and the response is registered.
// A new request is accepted only after the held one has executed.
// req_stall is high while a request is held; execution waits only while the
// response register is full and stalled.
// Reset clears the count and the valid flags; cell contents stay undefined.
module priority_ready_queue_unit
	import prq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	req_t             req_s1;
	logic             req_valid_s1;
	logic [CNT_W-1:0] count_q;
	rsp_t             rsp_q;
	logic             rsp_valid_q;

	logic             exec;
	logic             full;
	logic             empty;
	ctrl_t            ctrl;

	entry_t           ents  [QUEUE_DEPTH];
	link_t            links [QUEUE_DEPTH];
	logic             hits  [QUEUE_DEPTH];

	entry_t           sel_ent;
	rsp_t             rsp_d;
	logic [CNT_W-1:0] count_d;

	// A held request executes as soon as the response register can take it.
	assign exec      = req_valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = req_valid_s1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);

	// Refused inserts must not move the chain.
	assign ctrl.exec = exec && !((req_s1.func == FN_INSERT) && full);
	assign ctrl.func = req_s1.func;
	assign ctrl.pid  = req_s1.proc_id;
	assign ctrl.prio = PRIO_WIDTH'(req_s1.prio_in);

	// Cell 0 is the head. Insert shifts toward the tail from the insert point;
	// removals shift toward the head from the removed slot on.
	for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
		entry_t prv_ent;
		link_t  prv_link;
		entry_t nxt_ent;

		if (k == 0) begin : g_head
			assign prv_ent  = '{id: ctrl.pid, prio: ctrl.prio};
			assign prv_link = '0;
		end else begin : g_mid
			assign prv_ent  = ents[k-1];
			assign prv_link = links[k-1];
		end

		if (k == QUEUE_DEPTH - 1) begin : g_tail
			assign nxt_ent = '0;
		end else begin : g_body
			assign nxt_ent = ents[k+1];
		end

		prq_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.occ      (CNT_W'(k) < count_q),
			.prv_ent  (prv_ent),
			.prv_link (prv_link),
			.nxt_ent  (nxt_ent),
			.ent      (ents[k]),
			.link     (links[k]),
			.hit      (hits[k])
		);
	end

	// At most one cell reports the first id match.
	always_comb begin
		sel_ent = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (hits[i]) begin
				sel_ent = sel_ent | ents[i];
			end
		end
	end

	always_comb begin
		rsp_d   = '0;
		count_d = count_q;
		if (req_s1.func == FN_INSERT) begin
			if (full) begin
				rsp_d.status = ST_FULL;
			end else begin
				rsp_d.status   = ST_OK;
				rsp_d.out_id   = req_s1.proc_id;
				rsp_d.out_prio = PRIO_IN_W'(ctrl.prio);
				count_d        = count_q + CNT_W'(1);
			end
		end else if (empty) begin
			rsp_d.status = ST_EMPTY;
		end else begin
			unique case (req_s1.func)
				FN_PEEK, FN_POP: begin
					rsp_d.status   = ST_OK;
					rsp_d.out_id   = ents[0].id;
					rsp_d.out_prio = PRIO_IN_W'(ents[0].prio);
					if (req_s1.func == FN_POP) begin
						count_d = count_q - CNT_W'(1);
					end
				end
				FN_REMOVE: begin
					if (links[QUEUE_DEPTH-1].seen) begin
						rsp_d.status   = ST_OK;
						rsp_d.out_id   = sel_ent.id;
						rsp_d.out_prio = PRIO_IN_W'(sel_ent.prio);
						count_d        = count_q - CNT_W'(1);
					end else begin
						rsp_d.status = ST_NOT_FOUND;
					end
				end
				default: begin
					rsp_d.status = ST_OK;
				end
			endcase
		end
		rsp_d.is_empty  = (count_d == '0);
		rsp_d.occupancy = OCC_W'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
			count_q      <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (req_valid && !req_stall) begin
				req_valid_s1 <= 1'b1;
			end else if (exec) begin
				req_valid_s1 <= 1'b0;
			end
			if (exec) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
		if (exec) begin
			rsp_q <= rsp_d;
		end
	end

endmodule

[sv/prq_cell.sv]
// One slot of the sorted queue: holds an entry, compares it against the
// broadcast request and shifts toward head or tail. Depends on prq_pkg.
module prq_cell
	import prq_pkg::*;
(
	input  logic   clk,
	input  ctrl_t  ctrl,
	input  logic   occ,
	input  entry_t prv_ent,
	input  link_t  prv_link,
	input  entry_t nxt_ent,
	output entry_t ent,
	output link_t  link,
	output logic   hit
);

	entry_t ent_q;
	logic   match;

	assign match     = occ && (ent_q.id == ctrl.pid);
	assign link.ins  = !occ || (ent_q.prio <= ctrl.prio);
	assign link.seen = prv_link.seen | match;
	assign hit       = match & ~prv_link.seen;
	assign ent       = ent_q;

	always_ff @(posedge clk) begin
		if (ctrl.exec) begin
			unique case (ctrl.func)
				FN_INSERT: begin
					if (link.ins) begin
						if (prv_link.ins) begin
							ent_q <= prv_ent;
						end else begin
							ent_q <= '{id: ctrl.pid, prio: ctrl.prio};
						end
					end
				end
				FN_POP: begin
					ent_q <= nxt_ent;
				end
				FN_REMOVE: begin
					if (link.seen) begin
						ent_q <= nxt_ent;
					end
				end
				FN_PEEK: begin
				end
				default: begin
				end
			endcase
		end
	end

endmodule
